/* rtl/core/dss_pkg.sv */
// Shared types and codes for the two-stacks-in-one-array block.
// Used by the front decoder, the request queue, the back end and the top level.
package dss_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;

  // Request kinds as they arrive on the input stream
  localparam logic [KIND_W-1:0] KIND_PUSH_LO = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_LO  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_HI = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_HI  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP_LO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP_HI = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PUSHED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_POPPED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_ELEMENT   = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

  // Decoded operation carried from front to back
  typedef enum logic [2:0] {
    OP_PUSH_LO,
    OP_POP_LO,
    OP_PUSH_HI,
    OP_POP_HI,
    OP_DUMP_LO,
    OP_DUMP_HI
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // Write side of the request queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qwr_t;

endpackage

/* rtl/core/dss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/dss_front.sv */
// Front end: accepts requests from the input stream and decodes the kind.
// Depends on dss_pkg; feeds dss_queue.
module dss_front
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [DATA_W-1:0] in_value,
  output qwr_t              qwr,
  input  logic              q_ready
);

  op_t  op;
  logic op_ok;
  logic drops;

  // Decode kind; unknown kinds are taken and dropped
  always_comb begin
    op    = OP_PUSH_LO;
    op_ok = 1'b1;
    unique case (in_kind)
      KIND_PUSH_LO: op = OP_PUSH_LO;
      KIND_POP_LO:  op = OP_POP_LO;
      KIND_PUSH_HI: op = OP_PUSH_HI;
      KIND_POP_HI:  op = OP_POP_HI;
      KIND_DUMP_LO: op = OP_DUMP_LO;
      KIND_DUMP_HI: op = OP_DUMP_HI;
      default:      op_ok = 1'b0;
    endcase
  end

  assign in_ready      = q_ready;
  assign qwr.valid     = in_valid && op_ok;
  assign qwr.cmd.op    = op;
  assign qwr.cmd.value = in_value;

  // Flag dropped requests cycle by cycle, only for the check below
  assign drops = in_valid && in_ready && !op_ok;

  // A dropped request never reaches the queue
  assert property (@(posedge clk) disable iff (rst) drops |-> !qwr.valid)
    else $error("dss_front: unknown kind forwarded");

  // Anything forwarded carries a legal kind
  assert property (@(posedge clk) disable iff (rst)
    qwr.valid |-> (in_kind == KIND_PUSH_LO || in_kind == KIND_POP_LO ||
                   in_kind == KIND_PUSH_HI || in_kind == KIND_POP_HI ||
                   in_kind == KIND_DUMP_LO || in_kind == KIND_DUMP_HI))
    else $error("dss_front: illegal kind forwarded");

  // Forwarding only happens with the input valid
  assert property (@(posedge clk) disable iff (rst) qwr.valid |-> in_valid)
    else $error("dss_front: forward without input");

endmodule

/* rtl/core/dss_queue.sv */
// Two-entry request queue between the front and back ends.
// Depends on dss_pkg.
module dss_queue
  import dss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  qwr_t qwr,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_take
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = qwr.valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= qwr.cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Fill count never exceeds two entries
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("dss_queue: count overrun");

  // Pointers differ exactly when one entry is held
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) == (wr_ptr != rd_ptr))
    else $error("dss_queue: pointer mismatch");

  // A take only happens on a non-empty queue
  assert property (@(posedge clk) disable iff (rst) rd_take |-> rd_valid)
    else $error("dss_queue: take from empty queue");

endmodule

/* rtl/core/dss_back.sv */
// Back end: stack counters, shared RAM, read sequencer and output register.
// Depends on dss_pkg and dss_ram.
module dss_back
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_data,
  output logic              out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_M1 = CW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RD   = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     low_cnt, high_cnt;
  logic [CW-1:0]     low_cnt_next, high_cnt_next;
  logic              is_dump, is_dump_next;
  logic              dump_hi, dump_hi_next;
  logic [CW-1:0]     dump_idx, dump_idx_next;
  logic [CW-1:0]     dump_cnt, dump_cnt_next;

  logic              out_free;
  logic              out_load;
  logic [STAT_W-1:0] load_status;
  logic [DATA_W-1:0] load_data;
  logic              load_last;

  logic              full;
  logic [CW:0]       fill;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              elem_last;
  logic [CW-1:0]     idx_inc;

  assign out_free  = !out_valid || out_ready;
  assign fill      = {1'b0, low_cnt} + {1'b0, high_cnt};
  assign full      = (fill >= DEPTH_S);
  assign idx_inc   = dump_idx + CW'(1);
  assign elem_last = (idx_inc == dump_cnt);

  dss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(q_cmd.value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequence one request: execute push/pop, issue reads, walk dumps
  always_comb begin
    state_next    = state;
    low_cnt_next  = low_cnt;
    high_cnt_next = high_cnt;
    is_dump_next  = is_dump;
    dump_hi_next  = dump_hi;
    dump_idx_next = dump_idx;
    dump_cnt_next = dump_cnt;
    q_take        = 1'b0;
    out_load      = 1'b0;
    load_status   = ST_PUSHED;
    load_data     = '0;
    load_last     = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = low_cnt[AW-1:0];
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_take = 1'b1;
          unique case (q_cmd.op)
            OP_PUSH_LO: begin
              out_load = 1'b1;
              if (full) begin
                load_status = ST_OVERFLOW;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = low_cnt[AW-1:0];
                low_cnt_next = low_cnt + CW'(1);
              end
            end
            OP_PUSH_HI: begin
              out_load = 1'b1;
              if (full) begin
                load_status = ST_OVERFLOW;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = AW'(DEPTH_M1 - high_cnt);
                high_cnt_next = high_cnt + CW'(1);
              end
            end
            OP_POP_LO: begin
              if (low_cnt == '0) begin
                out_load    = 1'b1;
                load_status = ST_UNDERFLOW;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = AW'(low_cnt - CW'(1));
                low_cnt_next = low_cnt - CW'(1);
                is_dump_next = 1'b0;
                state_next   = S_RD;
              end
            end
            OP_POP_HI: begin
              if (high_cnt == '0) begin
                out_load    = 1'b1;
                load_status = ST_UNDERFLOW;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = AW'(DEPTH_C - high_cnt);
                high_cnt_next = high_cnt - CW'(1);
                is_dump_next  = 1'b0;
                state_next    = S_RD;
              end
            end
            OP_DUMP_LO: begin
              if (low_cnt == '0) begin
                out_load    = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = '0;
                is_dump_next  = 1'b1;
                dump_hi_next  = 1'b0;
                dump_idx_next = '0;
                dump_cnt_next = low_cnt;
                state_next    = S_RD;
              end
            end
            OP_DUMP_HI: begin
              if (high_cnt == '0) begin
                out_load    = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = AW'(DEPTH_M1);
                is_dump_next  = 1'b1;
                dump_hi_next  = 1'b1;
                dump_idx_next = '0;
                dump_cnt_next = high_cnt;
                state_next    = S_RD;
              end
            end
            default: q_take = 1'b1;
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_data = rd_data;
          if (is_dump) begin
            load_status = ST_ELEMENT;
            load_last   = elem_last;
            if (elem_last) begin
              state_next = S_IDLE;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = dump_hi ? AW'(DEPTH_M1 - idx_inc) : idx_inc[AW-1:0];
              dump_idx_next = idx_inc;
            end
          end else begin
            load_status = ST_POPPED;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      low_cnt   <= '0;
      high_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      low_cnt  <= low_cnt_next;
      high_cnt <= high_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and dump bookkeeping
  always_ff @(posedge clk) begin
    is_dump  <= is_dump_next;
    dump_hi  <= dump_hi_next;
    dump_idx <= dump_idx_next;
    dump_cnt <= dump_cnt_next;
    if (out_load) begin
      out_status <= load_status;
      out_data   <= load_data;
      out_last   <= load_last;
    end
  end

  // The two stacks never hold more than the array
  assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_S)
    else $error("dss_back: stacks overlap");

  // A write only lands when there is room
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("dss_back: write into full array");

  // A dump walk stays inside the stack it started on
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && is_dump) |-> (dump_idx < dump_cnt))
    else $error("dss_back: dump index past stack");

  // A new result is never loaded over one still waiting
  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("dss_back: result overwritten");

  // A request is taken only from idle
  assert property (@(posedge clk) disable iff (rst) q_take |-> state == S_IDLE)
    else $error("dss_back: request taken while busy");

endmodule

/* rtl/core/dual_stack_shared_array.sv */
// Top level of the two-stacks-in-one-array block.
// Depends on dss_pkg, dss_front, dss_queue, dss_back (and dss_ram below it).
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tuser = kind, tdata = push_value
//   m_*       out        m_tvalid/m_tready  tuser = status, tdata = data_out, tlast = last
//
// Requests pass the decoder into a two-entry queue; the back end takes one request
// at a time: push, failed pop and empty dump finish in idle, a pop makes one RAM
// read with registered data, and a dump of n elements makes one RAM read each.
// Synchronous active-high reset clears the stack counts; the RAM is not cleared.
// The output register reloads in the cycle its result is taken, so results stream
// while m_tready holds.
module dual_stack_shared_array
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tuser,   // [2:0] kind, [7:3] zero
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] push_value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tuser,   // [2:0] status, [7:3] zero
  output logic [DATA_W-1:0] m_tdata,   // [31:0] data_out
  output logic              m_tlast
);

  qwr_t              qwr;
  logic              q_ready;
  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_take;
  logic [STAT_W-1:0] status;

  dss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_kind (s_tuser[KIND_W-1:0]),
    .in_value(s_tdata),
    .qwr     (qwr),
    .q_ready (q_ready)
  );

  dss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .qwr     (qwr),
    .wr_ready(q_ready),
    .rd_valid(q_valid),
    .rd_cmd  (q_cmd),
    .rd_take (q_take)
  );

  dss_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(status),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

  assign m_tuser = {{(8 - STAT_W){1'b0}}, status};

endmodule

/* test/dual_stack_shared_array_tb.sv */
// Self-checking testbench for dual_stack_shared_array: push, pop and dump requests
// on both stacks, each result checked against a predicted stack image.
// Depends on dss_pkg and the dual_stack_shared_array RTL.
module dual_stack_shared_array_tb
  import dss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 10;

  // Kind codes the block decodes as no operation
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              last;
  } result_t;

  // Stack image, result prediction and result checking
  class stack_scoreboard;
    logic [DATA_W-1:0] store [DEPTH];
    int unsigned       low_count;
    int unsigned       high_count;
    result_t           pending_results [$];
    int unsigned       errors;

    function new();
      low_count = 0;
      high_count = 0;
      errors = 0;
    endfunction

    function void add_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data, logic last);
      result_t r;
      r.status = status;
      r.data = data;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the stack image by one accepted request and queue its results
    function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value);
      bit full;
      int unsigned i;
      full = (low_count + high_count) >= DEPTH;
      case (kind)
        KIND_PUSH_LO: begin
          if (full) begin
            add_result(ST_OVERFLOW, '0, 1'b1);
          end else begin
            store[low_count] = value;
            low_count++;
            add_result(ST_PUSHED, '0, 1'b1);
          end
        end
        KIND_POP_LO: begin
          if (low_count == 0) begin
            add_result(ST_UNDERFLOW, '0, 1'b1);
          end else begin
            low_count--;
            add_result(ST_POPPED, store[low_count], 1'b1);
          end
        end
        KIND_PUSH_HI: begin
          if (full) begin
            add_result(ST_OVERFLOW, '0, 1'b1);
          end else begin
            high_count++;
            store[DEPTH - high_count] = value;
            add_result(ST_PUSHED, '0, 1'b1);
          end
        end
        KIND_POP_HI: begin
          if (high_count == 0) begin
            add_result(ST_UNDERFLOW, '0, 1'b1);
          end else begin
            add_result(ST_POPPED, store[DEPTH - high_count], 1'b1);
            high_count--;
          end
        end
        KIND_DUMP_LO: begin
          if (low_count == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < low_count; i++)
              add_result(ST_ELEMENT, store[i], i + 1 == low_count);
          end
        end
        KIND_DUMP_HI: begin
          if (high_count == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < high_count; i++)
              add_result(ST_ELEMENT, store[DEPTH - 1 - i], i + 1 == high_count);
          end
        end
        default: ;  // spare kinds: no result, no state change
      endcase
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result status", DATA_W'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report("status", DATA_W'(status), DATA_W'(want.status));
        if (data !== want.data) report("data_out", data, want.data);
        if (last !== want.last) report("last", DATA_W'(last), DATA_W'(want.last));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tuser = '0;   // [2:0] kind, [7:3] zero
  logic [DATA_W-1:0] s_tdata = '0;   // [31:0] push_value
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tuser;        // [2:0] status, [7:3] zero
  logic [DATA_W-1:0] m_tdata;        // [31:0] data_out
  logic              m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  stack_scoreboard ledger;

  dual_stack_shared_array #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Check accepted results, then stall the output at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      ledger.check_result(m_tuser[STAT_W-1:0], m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {5'b0, kind};
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.note_request(kind, value);
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  // Random requests in segments that fill, drain or mix the two stacks
  task automatic random_phase(input int count);
    int sent;
    int seg_left;
    int r;
    int push_w;
    int pop_w;
    bit hi;
    mix_t mode;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    sent = 0;
    seg_left = 0;
    mode = MODE_FILL;
    while (sent < count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 15);
        mode = mix_t'($urandom_range(2));
      end
      case (mode)
        MODE_FILL: begin
          push_w = 70;
          pop_w = 12;
        end
        MODE_DRAIN: begin
          push_w = 12;
          pop_w = 70;
        end
        default: begin
          push_w = 40;
          pop_w = 40;
        end
      endcase
      hi = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 4)
        kind = $urandom_range(1) ? KIND_SPARE_B : KIND_SPARE_A;
      else if (r < 4 + push_w)
        kind = hi ? KIND_PUSH_HI : KIND_PUSH_LO;
      else if (r < 4 + push_w + pop_w)
        kind = hi ? KIND_POP_HI : KIND_POP_LO;
      else
        kind = hi ? KIND_DUMP_HI : KIND_DUMP_LO;
      case ($urandom_range(9))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = '1;
        default: value = $urandom;
      endcase
      send_request(kind, value);
      seg_left--;
      if (kind != KIND_SPARE_A && kind != KIND_SPARE_B) sent++;
    end
  endtask

  initial begin
    int i;
    ledger = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stacks, spare kinds, extreme values, full memory
    send_request(KIND_DUMP_LO, '0);
    send_request(KIND_DUMP_HI, '0);
    send_request(KIND_POP_LO, '0);
    send_request(KIND_POP_HI, '0);
    send_request(KIND_SPARE_A, '1);
    send_request(KIND_SPARE_B, '1);
    send_request(KIND_PUSH_LO, 32'h8000_0000);
    send_request(KIND_PUSH_LO, 32'h7FFF_FFFF);
    send_request(KIND_PUSH_HI, '1);
    send_request(KIND_PUSH_HI, '0);
    for (i = 0; i < DEPTH - 4; i++)
      send_request($urandom_range(1) ? KIND_PUSH_HI : KIND_PUSH_LO, $urandom);
    send_request(KIND_PUSH_LO, 32'h1234_5678);
    send_request(KIND_PUSH_HI, 32'h1234_5678);
    send_request(KIND_DUMP_LO, '0);
    send_request(KIND_DUMP_HI, '0);
    send_request(KIND_POP_LO, '0);
    send_request(KIND_POP_HI, '0);

    // Random traffic under each idling and stalling mix, draining in between
    random_phase(115);
    wait_for_results();
    idle_pct = 70;
    random_phase(115);
    wait_for_results();
    idle_pct = 0;
    stall_pct = 70;
    random_phase(115);
    wait_for_results();
    idle_pct = 27;
    stall_pct = 27;
    random_phase(115);
    wait_for_results();

    // Catch any stray result after the last prediction
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
